FILE: hw/rtl/ipti_pkg.sv
// ----------------------------------------------------------------------------
// ipti_pkg: shared types and constants for the partition table interpolator
// Table geometry, request codes, register indexes and the control group
// that travels with each request down the pipeline.
// ----------------------------------------------------------------------------
package ipti_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = ADDR_W + 1;

   // Q0.32 data, fraction bits of the index product
   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 32;
   localparam int SUM_W     = DATA_W + 1;
   localparam int INV_W     = 33;
   localparam int PROD_W    = DATA_W + INV_W;
   localparam int THR_W     = 16;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 33;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_X_MIN           = 3'd0,
      REG_X_MAX           = 3'd1,
      REG_X_STEP          = 3'd2,
      REG_INV_STEP        = 3'd3,
      REG_ENTRY_COUNT     = 3'd4,
      REG_SMALL_THRESHOLD = 3'd5
   } csr_index_type;

   // request kinds carried in tuser
   typedef enum logic [1:0] {
      FUNC_WR_FIRST  = 2'd0,
      FUNC_WR_SECOND = 2'd1,
      FUNC_QUERY     = 2'd2
   } func_type;

   // result paths carried in tuser
   typedef enum logic [1:0] {
      PATH_FIRST   = 2'd0,
      PATH_BALANCE = 2'd1,
      PATH_KEPT    = 2'd2
   } path_type;

   // per-stage control: at most one bit set, none for a bubble
   typedef struct packed {
      logic query;
      logic wr_first;
      logic wr_second;
   } ctl_type;

endpackage

FILE: hw/rtl/interface_partition_table_interp_top.sv
// ----------------------------------------------------------------------------
// interface_partition_table_interp_top: partition table interpolator
// Two equidistant equilibrium tables, a clamped linear lookup of the mean of
// two concentrations, and a fallback through the second-phase table.
//
// Usage:
//   req channel: tuser selects the request (write first table, write second
//   table, query); tdata carries the entry index and value for writes and
//   the two current concentrations for queries. Writes produce no result;
//   each query produces one result on the rsp channel, in request order.
//   csr channel: register writes, always ready; write only while no query is
//   in flight. x_step is accepted but not held, the datapath uses inv_step.
//   Throughput: one request per cycle. A query's result passes two front
//   stages, the table read, three interpolation stages and the result
//   register, in that order.
//   The pipeline advances as a whole; when the rsp side stalls with a result
//   waiting, req_tready drops and every stage holds.
//   Reset clears the pipeline valids and loads register defaults. Table
//   contents are undefined until written; there is no clearing pass.
// ----------------------------------------------------------------------------
module interface_partition_table_interp_top import ipti_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [9:0] entry_index, [41:10] entry_value, [73:42] second_phase_now,
   // [105:74] first_phase_now, [111:106] zero
   input  logic [111:0]          req_tdata,
   // [1:0] func
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] first_phase_eq
   output logic [DATA_W-1:0]     rsp_tdata,
   // [1:0] path_taken
   output logic [1:0]            rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // configuration registers
   logic [DATA_W-1:0]  x_min_ff;
   logic [DATA_W-1:0]  x_max_ff;
   logic [INV_W-1:0]   inv_step_ff;
   logic [COUNT_W-1:0] entry_count_ff;
   logic [THR_W-1:0]   thr_ff;
   logic [ADDR_W-1:0]  last_index;

   // pipeline control
   logic                advance;
   ctl_type             in_ctl;
   ctl_type             ctl2;
   logic [ADDR_W-1:0]   index2;
   logic [DATA_W-1:0]   value2;
   logic [SUM_W-1:0]    sum2;
   logic [DATA_W-1:0]   first2;
   logic [PROD_W-1:0]   prod2;

   // stage 3 addressing
   logic [PROD_W-FRAC_BITS-1:0] idx_int;
   logic [ADDR_W-1:0]    addr0;
   logic [ADDR_W-1:0]    addr1;
   logic [FRAC_BITS-1:0] frac3_in;
   logic [FRAC_BITS-1:0] frac3_ff;

   // query stages 3 to 6
   logic [3:0]          query_ff;
   logic [SUM_W-1:0]    sum_ff   [4];
   logic [DATA_W-1:0]   first_ff [4];

   // table data and interpolated values
   logic [DATA_W-1:0]   t1_y0;
   logic [DATA_W-1:0]   t1_y1;
   logic [DATA_W-1:0]   t2_y0;
   logic [DATA_W-1:0]   t2_y1;
   logic [DATA_W-1:0]   f1;
   logic [DATA_W-1:0]   f2;

   // result register
   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   rsp_data_ff;
   logic [DATA_W-1:0]   rsp_data_in;
   logic [1:0]          rsp_path_ff;
   logic [1:0]          rsp_path_in;
   logic [SUM_W-1:0]    bal2;
   logic                first_ok;
   logic                second_fail;

   // config write port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff       <= '0;
         x_max_ff       <= '1;
         inv_step_ff    <= INV_W'(1024);
         entry_count_ff <= COUNT_W'(TABLE_DEPTH);
         thr_ff         <= THR_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            REG_X_MIN:           x_min_ff       <= csr_data[DATA_W-1:0];
            REG_X_MAX:           x_max_ff       <= csr_data[DATA_W-1:0];
            REG_INV_STEP:        inv_step_ff    <= csr_data[INV_W-1:0];
            REG_ENTRY_COUNT:     entry_count_ff <= csr_data[COUNT_W-1:0];
            REG_SMALL_THRESHOLD: thr_ff         <= csr_data[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // last usable entry: count 0 acts as 1, counts above depth as depth
   always_comb begin
      if (entry_count_ff == '0) begin
         last_index = '0;
      end else if (entry_count_ff > COUNT_W'(TABLE_DEPTH)) begin
         last_index = ADDR_W'(TABLE_DEPTH - 1);
      end else begin
         last_index = ADDR_W'(entry_count_ff - COUNT_W'(1));
      end
   end

   // whole pipeline moves unless a result is waiting on a stalled receiver
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // request decode
   always_comb begin
      in_ctl.query     = req_tvalid && (req_tuser == FUNC_QUERY);
      in_ctl.wr_first  = req_tvalid && (req_tuser == FUNC_WR_FIRST);
      in_ctl.wr_second = req_tvalid && (req_tuser == FUNC_WR_SECOND);
   end

   ipti_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_ctl    (in_ctl),
      .in_index  (req_tdata[9:0]),
      .in_value  (req_tdata[41:10]),
      .in_second (req_tdata[73:42]),
      .in_first  (req_tdata[105:74]),
      .x_min     (x_min_ff),
      .x_max     (x_max_ff),
      .inv_step  (inv_step_ff),
      .out_ctl   (ctl2),
      .out_index (index2),
      .out_value (value2),
      .out_sum   (sum2),
      .out_first (first2),
      .out_prod  (prod2)
   );

   // index clamp: past the last pair, read the last entry twice with zero weight
   always_comb begin
      idx_int = prod2[PROD_W-1:FRAC_BITS];
      if (idx_int >= (PROD_W-FRAC_BITS)'(last_index)) begin
         addr0    = last_index;
         addr1    = last_index;
         frac3_in = '0;
      end else begin
         addr0    = idx_int[ADDR_W-1:0];
         addr1    = idx_int[ADDR_W-1:0] + ADDR_W'(1);
         frac3_in = prod2[FRAC_BITS-1:0];
      end
   end

   // table writes happen at the read stage so requests stay in order
   ipti_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_first_table (
      .clock     (clock),
      .wr_en     (advance && ctl2.wr_first),
      .wr_addr   (index2),
      .wr_data   (value2),
      .rd_en     (advance),
      .rd_addr_a (addr0),
      .rd_addr_b (addr1),
      .rd_data_a (t1_y0),
      .rd_data_b (t1_y1)
   );

   ipti_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_second_table (
      .clock     (clock),
      .wr_en     (advance && ctl2.wr_second),
      .wr_addr   (index2),
      .wr_data   (value2),
      .rd_en     (advance),
      .rd_addr_a (addr0),
      .rd_addr_b (addr1),
      .rd_data_a (t2_y0),
      .rd_data_b (t2_y1)
   );

   ipti_interp u_interp_first (
      .clock   (clock),
      .advance (advance),
      .y0      (t1_y0),
      .y1      (t1_y1),
      .frac    (frac3_ff),
      .value   (f1)
   );

   ipti_interp u_interp_second (
      .clock   (clock),
      .advance (advance),
      .y0      (t2_y0),
      .y1      (t2_y1),
      .frac    (frac3_ff),
      .value   (f2)
   );

   // query valids through stages 3 to 6
   always_ff @(posedge clock) begin
      if (reset) begin
         query_ff <= '0;
      end else if (advance) begin
         query_ff <= {query_ff[2:0], ctl2.query};
      end
   end

   // query payload through stages 3 to 6
   always_ff @(posedge clock) begin
      if (advance) begin
         frac3_ff    <= frac3_in;
         sum_ff[0]   <= sum2;
         first_ff[0] <= first2;
         for (int k = 1; k < 4; k++) begin
            sum_ff[k]   <= sum_ff[k-1];
            first_ff[k] <= first_ff[k-1];
         end
      end
   end

   // path select: first table, balance through second table, or keep
   always_comb begin
      first_ok    = ({1'b0, sum_ff[3]} >= ((SUM_W+1)'(f1) + (SUM_W+1)'(thr_ff)));
      second_fail = (f2 < DATA_W'(thr_ff)) ||
                    ({1'b0, sum_ff[3]} < ((SUM_W+1)'(f2) + (SUM_W+1)'(thr_ff)));
      bal2        = sum_ff[3] - SUM_W'(f2);
      if (first_ok) begin
         rsp_data_in = f1;
         rsp_path_in = PATH_FIRST;
      end else if (second_fail) begin
         rsp_data_in = first_ff[3];
         rsp_path_in = PATH_KEPT;
      end else begin
         rsp_data_in = bal2[SUM_W-1] ? '1 : bal2[DATA_W-1:0];
         rsp_path_in = PATH_BALANCE;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= query_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (advance && query_ff[3]) begin
         rsp_data_ff <= rsp_data_in;
         rsp_path_ff <= rsp_path_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_path_ff;

endmodule

FILE: hw/rtl/ipti_ram.sv
// ----------------------------------------------------------------------------
// ipti_ram: generic table memory
// One write port and two read ports, read data registered under rd_en.
// ----------------------------------------------------------------------------
module ipti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: hw/rtl/ipti_front.sv
// ----------------------------------------------------------------------------
// ipti_front: mean, clamp and index product
// Stage 1 forms the sum and the clamped mean, stage 2 the product of the
// offset from x_min with the reciprocal step.
// ----------------------------------------------------------------------------
module ipti_front import ipti_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  ctl_type             in_ctl,
   input  logic [ADDR_W-1:0]   in_index,
   input  logic [DATA_W-1:0]   in_value,
   input  logic [DATA_W-1:0]   in_second,
   input  logic [DATA_W-1:0]   in_first,
   input  logic [DATA_W-1:0]   x_min,
   input  logic [DATA_W-1:0]   x_max,
   input  logic [INV_W-1:0]    inv_step,
   output ctl_type             out_ctl,
   output logic [ADDR_W-1:0]   out_index,
   output logic [DATA_W-1:0]   out_value,
   output logic [SUM_W-1:0]    out_sum,
   output logic [DATA_W-1:0]   out_first,
   output logic [PROD_W-1:0]   out_prod
);

   // stage 1 registers
   ctl_type             ctl1_ff;
   logic [ADDR_W-1:0]   index1_ff;
   logic [DATA_W-1:0]   value1_ff;
   logic [SUM_W-1:0]    sum1_ff;
   logic [SUM_W-1:0]    sum1_in;
   logic [DATA_W-1:0]   mean1_ff;
   logic [DATA_W-1:0]   mean1_in;
   logic [DATA_W-1:0]   first1_ff;

   // stage 2 registers
   ctl_type             ctl2_ff;
   logic [ADDR_W-1:0]   index2_ff;
   logic [DATA_W-1:0]   value2_ff;
   logic [SUM_W-1:0]    sum2_ff;
   logic [DATA_W-1:0]   first2_ff;
   logic [PROD_W-1:0]   prod2_ff;
   logic [PROD_W-1:0]   prod2_in;
   logic [DATA_W-1:0]   offset;
   logic [DATA_W-1:0]   mean_hi;

   // sum is twice the mean; clamp to x_max first, then x_min wins
   always_comb begin
      sum1_in  = SUM_W'(in_second) + SUM_W'(in_first);
      mean_hi  = (sum1_in[SUM_W-1:1] > x_max) ? x_max : sum1_in[SUM_W-1:1];
      mean1_in = (mean_hi < x_min) ? x_min : mean_hi;
   end

   // offset times reciprocal step, FRAC_BITS fraction bits
   always_comb begin
      offset   = mean1_ff - x_min;
      prod2_in = PROD_W'(offset) * PROD_W'(inv_step);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else if (advance) begin
         ctl1_ff <= in_ctl;
         ctl2_ff <= ctl1_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         index1_ff <= in_index;
         value1_ff <= in_value;
         sum1_ff   <= sum1_in;
         mean1_ff  <= mean1_in;
         first1_ff <= in_first;
         index2_ff <= index1_ff;
         value2_ff <= value1_ff;
         sum2_ff   <= sum1_ff;
         first2_ff <= first1_ff;
         prod2_ff  <= prod2_in;
      end
   end

   assign out_ctl   = ctl2_ff;
   assign out_index = index2_ff;
   assign out_value = value2_ff;
   assign out_sum   = sum2_ff;
   assign out_first = first2_ff;
   assign out_prod  = prod2_ff;

endmodule

FILE: hw/rtl/ipti_interp.sv
// ----------------------------------------------------------------------------
// ipti_interp: linear interpolation between two table entries
// Three stages: magnitude of the step, product with the weight, then the
// correction applied toward y1 and truncated toward y0.
// ----------------------------------------------------------------------------
module ipti_interp import ipti_pkg::*; (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [DATA_W-1:0]    y0,
   input  logic [DATA_W-1:0]    y1,
   input  logic [FRAC_BITS-1:0] frac,
   output logic [DATA_W-1:0]    value
);

   logic [DATA_W-1:0]    y0_4_ff;
   logic [DATA_W-1:0]    diff_4_ff;
   logic                 neg_4_ff;
   logic [FRAC_BITS-1:0] frac_4_ff;
   logic [DATA_W-1:0]    y0_5_ff;
   logic                 neg_5_ff;
   logic [DATA_W-1:0]    delta_5_ff;
   logic [DATA_W-1:0]    value_6_ff;
   logic [DATA_W-1:0]    value_6_in;
   logic [DATA_W+FRAC_BITS-1:0] prod;
   logic                 neg;

   // step magnitude, product with the weight and the corrected value
   always_comb begin
      neg  = (y1 < y0);
      prod = (DATA_W+FRAC_BITS)'(diff_4_ff) * (DATA_W+FRAC_BITS)'(frac_4_ff);
      value_6_in = neg_5_ff ? (y0_5_ff - delta_5_ff) : (y0_5_ff + delta_5_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         y0_4_ff    <= y0;
         diff_4_ff  <= neg ? (y0 - y1) : (y1 - y0);
         neg_4_ff   <= neg;
         frac_4_ff  <= frac;
         y0_5_ff    <= y0_4_ff;
         neg_5_ff   <= neg_4_ff;
         delta_5_ff <= prod[DATA_W+FRAC_BITS-1:FRAC_BITS];
         value_6_ff <= value_6_in;
      end
   end

   assign value = value_6_ff;

endmodule
